// ===== rtl/core/crrg_pkg.sv =====
// Shared types, register codes and constants for the chroma remap/rotate/gain block.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none
package crrg_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 4;
  localparam int BLEND_W    = 10;
  localparam int GAIN_W     = 11;
  localparam int ROT_W      = 11;

  localparam int NSTAGE     = 6;

  // Reset values of the control registers
  localparam logic [BLEND_W-1:0]       BLEND_RST = 10'd720;
  localparam logic [GAIN_W-1:0]        GAIN_RST  = 11'd1100;
  localparam logic signed [ROT_W-1:0]  ROT_RST   = 11'sd0;

  // Register limits
  localparam logic [BLEND_W-1:0]       BLEND_MAX = 10'd1000;
  localparam logic [GAIN_W-1:0]        GAIN_MAX  = 11'd2000;
  localparam logic signed [ROT_W-1:0]  ROT_MAX   = 11'sd1000;
  localparam logic signed [ROT_W-1:0]  ROT_MIN   = -11'sd1000;

  localparam logic [7:0] AA_BASE = 8'haa;

  // Divide by 1000: floor(n / 1000) == (n * DIV_MUL) >> DIV_SHIFT for n < 2**NUM_W
  localparam int NUM_W     = 18;
  localparam int DIV_SHIFT = 28;
  localparam int PROD_W    = 37;
  localparam logic [PROD_W-1:0] DIV_MUL = 37'd268436;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 8'd0,
    REG_BLEND  = 8'd1,
    REG_GAIN   = 8'd2,
    REG_ROTATE = 8'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_INV_B     = 4'd0,  // (255-cb, cr)
    MODE_INV_R     = 4'd1,  // (cb, 255-cr)
    MODE_INV_BR    = 4'd2,  // (255-cb, 255-cr)
    MODE_SWAP      = 4'd3,  // (cr, cb)
    MODE_RINV_TO_B = 4'd4,  // (255-cr, cr)
    MODE_BINV_TO_R = 4'd5,  // (cb, 255-cb)
    MODE_CROSS_INV = 4'd6,  // (255-cr, 255-cb)
    MODE_TURN_A    = 4'd7,  // (255-cr, cb)
    MODE_TURN_B    = 4'd8,  // (cr, 255-cb)
    MODE_AA_SUB    = 4'd9   // (0xaa-cb wrapped, cr)
  } mode_e;

  typedef struct packed {
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_req_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] red_out;
  } out_req_t;

  typedef struct packed {
    logic [7:0] cb;
    logic [7:0] cr;
  } pix_t;

  typedef struct packed {
    mode_e              mode;
    logic [BLEND_W-1:0] blend;
    logic [GAIN_W-1:0]  gain;
    logic [BLEND_W-1:0] rot_mag;
    logic               rot_neg;
  } cfg_t;

  // Load enables of a two-register section
  typedef struct packed {
    logic en_num;
    logic en_prod;
  } pipe_ctl_t;

  function automatic logic [PROD_W-1:0] recip_mul(input logic [NUM_W-1:0] n);
    return PROD_W'(n) * DIV_MUL;
  endfunction

  function automatic logic [7:0] recip_quot(input logic [PROD_W-1:0] p);
    return p[DIV_SHIFT+7:DIV_SHIFT];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/chroma_remap_rotate_gain_top.sv =====
// Chroma remap/rotate/gain, top level. Throughput: one Cb/Cr request per clock while
// out_stall is low. Six pipeline registers, two per blend section and two for gain,
// feed the output register.
// Stalls collapse bubbles stage by stage; with out_stall low, in_stall is low.
// Reset (rst_n, synchronous): all valid bits clear, control registers take their reset values.
`default_nettype none
module chroma_remap_rotate_gain_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  crrg_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output crrg_pkg::out_req_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crrg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crrg_pkg::*;

  cfg_t       cfg;
  pix_t       src0, tgt0;       // input pair and mode target
  pix_t       mix1, tgt1;       // after mode blend, rotation target
  pix_t       mix2, fin;        // after rotation, after gain and clamp
  pipe_ctl_t  ctl_mode, ctl_rot, ctl_gain;

  logic [NSTAGE-1:0] v_r, v_nxt;
  logic [NSTAGE-1:0] en;
  logic              en_out;
  logic              out_valid_r, out_valid_nxt;
  out_req_t          out_data_r;

  crrg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage load enables: a stage loads when empty or when the stage after it moves.
  always_comb begin
    en_out         = !out_valid_r || !out_stall;
    en[NSTAGE-1]   = !v_r[NSTAGE-1] || en_out;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
    out_valid_nxt = en_out ? v_r[NSTAGE-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Mode target: inversions (255-x is ~x), swaps, cross mixes, 0xaa-cb wrapped.
  assign src0.cb = in_data.chroma_blue;
  assign src0.cr = in_data.chroma_red;

  always_comb begin
    tgt0 = src0;
    case (cfg.mode)
      MODE_INV_B:     tgt0.cb = ~src0.cb;
      MODE_INV_R:     tgt0.cr = ~src0.cr;
      MODE_INV_BR: begin
        tgt0.cb = ~src0.cb;
        tgt0.cr = ~src0.cr;
      end
      MODE_SWAP: begin
        tgt0.cb = src0.cr;
        tgt0.cr = src0.cb;
      end
      MODE_RINV_TO_B: tgt0.cb = ~src0.cr;
      MODE_BINV_TO_R: tgt0.cr = ~src0.cb;
      MODE_CROSS_INV: begin
        tgt0.cb = ~src0.cr;
        tgt0.cr = ~src0.cb;
      end
      MODE_TURN_A: begin
        tgt0.cb = ~src0.cr;
        tgt0.cr = src0.cb;
      end
      MODE_TURN_B: begin
        tgt0.cb = src0.cr;
        tgt0.cr = ~src0.cb;
      end
      MODE_AA_SUB:    tgt0.cb = AA_BASE - src0.cb;
      default: begin
      end
    endcase
  end

  assign ctl_mode.en_num  = en[0];
  assign ctl_mode.en_prod = en[1];

  crrg_blend u_blend_mode (
    .clk (clk),
    .ctl (ctl_mode),
    .src (src0),
    .tgt (tgt0),
    .q   (cfg.blend),
    .res (mix1)
  );

  // Rotation: positive turns toward (cr, 255-cb), negative toward (255-cr, cb).
  // Zero weight leaves the pair as is, so no separate bypass.
  always_comb begin
    if (cfg.rot_neg) begin
      tgt1.cb = ~mix1.cr;
      tgt1.cr = mix1.cb;
    end else begin
      tgt1.cb = mix1.cr;
      tgt1.cr = ~mix1.cb;
    end
  end

  assign ctl_rot.en_num  = en[2];
  assign ctl_rot.en_prod = en[3];

  crrg_blend u_blend_rot (
    .clk (clk),
    .ctl (ctl_rot),
    .src (mix1),
    .tgt (tgt1),
    .q   (cfg.rot_mag),
    .res (mix2)
  );

  assign ctl_gain.en_num  = en[4];
  assign ctl_gain.en_prod = en[5];

  crrg_gain u_gain (
    .clk  (clk),
    .ctl  (ctl_gain),
    .c    (mix2),
    .gain (cfg.gain),
    .res  (fin)
  );

  // Output register: holds while stalled, frees the pipe behind it otherwise.
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r.blue_out <= fin.cb;
      out_data_r.red_out  <= fin.cr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/crrg_cfg.sv =====
// Control registers with saturating writes; exports the live settings as one struct.
// Depends on crrg_pkg.
`default_nettype none
module crrg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crrg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output crrg_pkg::cfg_t                   cfg
);
  import crrg_pkg::*;

  mode_e                    mode_r, mode_nxt;
  logic [BLEND_W-1:0]       blend_r, blend_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic signed [ROT_W-1:0]  rot_r, rot_nxt;
  logic signed [ROT_W-1:0]  rot_wr;
  logic signed [ROT_W-1:0]  rot_abs;

  assign cfg_ready = 1'b1;
  assign rot_wr    = $signed(cfg_data[ROT_W-1:0]);

  always_comb begin
    mode_nxt  = mode_r;
    blend_nxt = blend_r;
    gain_nxt  = gain_r;
    rot_nxt   = rot_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: begin
          mode_nxt = (cfg_data[MODE_W-1:0] > MODE_AA_SUB) ? MODE_AA_SUB
                                                          : mode_e'(cfg_data[MODE_W-1:0]);
        end
        REG_BLEND: begin
          blend_nxt = (cfg_data[BLEND_W-1:0] > BLEND_MAX) ? BLEND_MAX : cfg_data[BLEND_W-1:0];
        end
        REG_GAIN: begin
          gain_nxt = (cfg_data[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : cfg_data[GAIN_W-1:0];
        end
        REG_ROTATE: begin
          if (rot_wr > ROT_MAX) begin
            rot_nxt = ROT_MAX;
          end else if (rot_wr < ROT_MIN) begin
            rot_nxt = ROT_MIN;
          end else begin
            rot_nxt = rot_wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INV_B;
      blend_r <= BLEND_RST;
      gain_r  <= GAIN_RST;
      rot_r   <= ROT_RST;
    end else begin
      mode_r  <= mode_nxt;
      blend_r <= blend_nxt;
      gain_r  <= gain_nxt;
      rot_r   <= rot_nxt;
    end
  end

  assign rot_abs = rot_r[ROT_W-1] ? -rot_r : rot_r;

  always_comb begin
    cfg.mode    = mode_r;
    cfg.blend   = blend_r;
    cfg.gain    = gain_r;
    cfg.rot_mag = rot_abs[BLEND_W-1:0];
    cfg.rot_neg = rot_r[ROT_W-1];
  end

endmodule
`default_nettype wire

// ===== rtl/core/crrg_blend.sv =====
// Two-lane blend a + (b - a) * q / 1000 with round half up, in two register stages:
// numerator, then reciprocal product. Depends on crrg_pkg.
`default_nettype none
module crrg_blend (
  input  logic                           clk,
  input  crrg_pkg::pipe_ctl_t            ctl,
  input  crrg_pkg::pix_t                 src,
  input  crrg_pkg::pix_t                 tgt,
  input  logic [crrg_pkg::BLEND_W-1:0]   q,
  output crrg_pkg::pix_t                 res
);
  import crrg_pkg::*;

  // a*1000 + (b-a)*q + 500, never negative, at most 255500
  function automatic logic [NUM_W-1:0] blend_num(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [BLEND_W-1:0] w);
    logic signed [8:0]  diff;
    logic signed [20:0] base, term, sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    base = $signed({13'b0, a}) * 21'sd1000;
    term = 21'(diff) * $signed({11'b0, w});
    sum  = base + term + 21'sd500;
    return sum[NUM_W-1:0];
  endfunction

  logic [NUM_W-1:0]  num_b_r, num_b_nxt, num_r_r, num_r_nxt;
  logic [PROD_W-1:0] prod_b_r, prod_b_nxt, prod_r_r, prod_r_nxt;

  always_comb begin
    num_b_nxt  = blend_num(src.cb, tgt.cb, q);
    num_r_nxt  = blend_num(src.cr, tgt.cr, q);
    prod_b_nxt = recip_mul(num_b_r);
    prod_r_nxt = recip_mul(num_r_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_num) begin
      num_b_r <= num_b_nxt;
      num_r_r <= num_r_nxt;
    end
    if (ctl.en_prod) begin
      prod_b_r <= prod_b_nxt;
      prod_r_r <= prod_r_nxt;
    end
  end

  assign res.cb = recip_quot(prod_b_r);
  assign res.cr = recip_quot(prod_r_r);

endmodule
`default_nettype wire

// ===== rtl/core/crrg_gain.sv =====
// Two-lane gain about 128 in thousandths, truncating toward zero, then clamp to a byte.
// Two register stages: signed product magnitude, then reciprocal product. Uses crrg_pkg.
`default_nettype none
module crrg_gain (
  input  logic                          clk,
  input  crrg_pkg::pipe_ctl_t           ctl,
  input  crrg_pkg::pix_t                c,
  input  logic [crrg_pkg::GAIN_W-1:0]   gain,
  output crrg_pkg::pix_t                res
);
  import crrg_pkg::*;

  // {sign, |(c-128)*g + 500|}
  function automatic logic [NUM_W:0] gain_num(input logic [7:0] x, input logic [GAIN_W-1:0] g);
    logic signed [8:0]  cm;
    logic signed [20:0] gp, mag;
    cm  = $signed({1'b0, x}) - 9'sd128;
    gp  = 21'(cm) * $signed({10'b0, g}) + 21'sd500;
    mag = gp[20] ? -gp : gp;
    return {gp[20], mag[NUM_W-1:0]};
  endfunction

  function automatic logic [7:0] clamp_mid(input logic neg, input logic [7:0] d);
    logic signed [9:0] v;
    v = neg ? (10'sd128 - $signed({2'b0, d})) : (10'sd128 + $signed({2'b0, d}));
    if (v < 10'sd0) begin
      return 8'd0;
    end else if (v > 10'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  logic [NUM_W:0]    num_b_r, num_b_nxt, num_r_r, num_r_nxt;
  logic [PROD_W-1:0] prod_b_r, prod_b_nxt, prod_r_r, prod_r_nxt;
  logic              neg_b_r, neg_r_r;

  always_comb begin
    num_b_nxt  = gain_num(c.cb, gain);
    num_r_nxt  = gain_num(c.cr, gain);
    prod_b_nxt = recip_mul(num_b_r[NUM_W-1:0]);
    prod_r_nxt = recip_mul(num_r_r[NUM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_num) begin
      num_b_r <= num_b_nxt;
      num_r_r <= num_r_nxt;
    end
    if (ctl.en_prod) begin
      prod_b_r <= prod_b_nxt;
      prod_r_r <= prod_r_nxt;
      neg_b_r  <= num_b_r[NUM_W];
      neg_r_r  <= num_r_r[NUM_W];
    end
  end

  assign res.cb = clamp_mid(neg_b_r, recip_quot(prod_b_r));
  assign res.cr = clamp_mid(neg_r_r, recip_quot(prod_r_r));

endmodule
`default_nettype wire

// ===== rtl/core/crrg_checker.sv =====
// Port-level checks for chroma_remap_rotate_gain_top, plus the bind that attaches them.
// Depends on crrg_pkg and the top-level port list.
`default_nettype none
module crrg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input crrg_pkg::out_req_t  out_data
);

  // A pending result keeps its value while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // A result is never dropped while stalled.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped under stall");

  // Input back-pressure only comes from a blocked output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind chroma_remap_rotate_gain_top crrg_checker u_crrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== sim/chroma_remap_rotate_gain_top_tb.sv =====
// Self-checking bench for chroma_remap_rotate_gain_top: Cb/Cr requests and register writes
// with random idling and a forced back-pressure stretch. Needs rtl/core/crrg_pkg.sv and the top.
`default_nettype none
module chroma_remap_rotate_gain_top_tb;
  import crrg_pkg::*;

  localparam int LIMIT_TU     = 2_000_000;  // run-away guard, time units
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 64;         // long receiver hold-off
  localparam int DRAIN_GUARD  = 20_000;

  // Scoreboard: own copy of the four registers plus the pixel math.
  // Each accepted request pushes its predicted pair; each result pops one.
  class chroma_scoreboard;
    mode_e    mode;
    int       blend;
    int       gain;
    int       rot;
    out_req_t expected_q[$];
    int       errors;

    function void reset_regs();
      mode   = MODE_INV_B;
      blend  = int'(BLEND_RST);
      gain   = int'(GAIN_RST);
      rot    = int'(ROT_RST);
      errors = 0;
    endfunction

    // Mask to register width, then saturate; unknown index is dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      int v;
      case (idx)
        REG_MODE: begin
          v = int'(val[MODE_W-1:0]);
          if (v > int'(MODE_AA_SUB)) v = int'(MODE_AA_SUB);
          mode = mode_e'(v);
        end
        REG_BLEND: begin
          v = int'(val[BLEND_W-1:0]);
          blend = (v > int'(BLEND_MAX)) ? int'(BLEND_MAX) : v;
        end
        REG_GAIN: begin
          v = int'(val[GAIN_W-1:0]);
          gain = (v > int'(GAIN_MAX)) ? int'(GAIN_MAX) : v;
        end
        REG_ROTATE: begin
          v = int'($signed(val[ROT_W-1:0]));
          if (v > int'(ROT_MAX)) v = int'(ROT_MAX);
          if (v < int'(ROT_MIN)) v = int'(ROT_MIN);
          rot = v;
        end
        default: ;
      endcase
    endfunction

    // (a*(1000-q) + b*q + 500) / 1000, all terms non-negative
    function int mix(int a, int b, int q);
      return (a * (1000 - q) + b * q + 500) / 1000;
    endfunction

    // Scale about mid-gray; SV int division truncates toward zero
    function int gain_mid(int c);
      int d;
      d = ((c - 128) * gain + 500) / 1000;
      c = 128 + d;
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      return c;
    endfunction

    function out_req_t remap(in_req_t px);
      int cb, cr, tb, tr, nb, nr;
      out_req_t res;
      cb = int'(px.chroma_blue);
      cr = int'(px.chroma_red);
      tb = cb;
      tr = cr;
      case (mode)
        MODE_INV_B:     tb = 255 - cb;
        MODE_INV_R:     tr = 255 - cr;
        MODE_INV_BR:    begin tb = 255 - cb; tr = 255 - cr; end
        MODE_SWAP:      begin tb = cr;       tr = cb;       end
        MODE_RINV_TO_B: tb = 255 - cr;
        MODE_BINV_TO_R: tr = 255 - cb;
        MODE_CROSS_INV: begin tb = 255 - cr; tr = 255 - cb; end
        MODE_TURN_A:    begin tb = 255 - cr; tr = cb;       end
        MODE_TURN_B:    begin tb = cr;       tr = 255 - cb; end
        MODE_AA_SUB:    tb = (int'(AA_BASE) - cb) & 255;
        default: ;
      endcase
      nb = mix(cb, tb, blend);
      nr = mix(cr, tr, blend);
      cb = nb;
      cr = nr;
      if (rot > 0) begin
        nb = mix(cb, cr, rot);
        nr = mix(cr, 255 - cb, rot);
      end else if (rot < 0) begin
        nb = mix(cb, 255 - cr, -rot);
        nr = mix(cr, cb, -rot);
      end
      res.blue_out = 8'(gain_mid(nb));
      res.red_out  = 8'(gain_mid(nr));
      return res;
    endfunction

    function void note_request(in_req_t px);
      expected_q.push_back(remap(px));
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result blue=%0d red=%0d", $time,
                 got.blue_out, got.red_out);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.blue_out !== want.blue_out) begin
        $display("%0t: blue_out expected %0d actual %0d", $time,
                 want.blue_out, got.blue_out);
        errors++;
      end
      if (got.red_out !== want.red_out) begin
        $display("%0t: red_out expected %0d actual %0d", $time,
                 want.red_out, got.red_out);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Ports: everything the bench drives starts at a known value
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  chroma_scoreboard sb = new();

  // Idle percentages per side; only changed while the block is empty
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  // Set once by the stimulus; the result side then holds off on its own count
  bit hold_armed    = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;

  chroma_remap_rotate_gain_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side. Samples the pre-edge handshake, then picks the stall for the
  // next cycle. A result is taken when out_valid was high and out_stall low.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // One register write. cfg_valid stays up across back-to-back writes; the
  // caller drops it after the last one so it never toggles within a step.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // One pixel request. Idle gaps come before the request; valid is only
  // lowered when a gap is taken, so back-to-back requests keep it high.
  task automatic send_pix(input logic [7:0] cb, input logic [7:0] cr);
    in_req_t px;
    px.chroma_blue = cb;
    px.chroma_red  = cr;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(px);
  endtask

  // Wait until every predicted pair has come back, then let the pipe settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (NSTAGE + 2) @(posedge clk);
  endtask

  // Biased toward the byte extremes and mid-gray
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // New random setting for all four registers; raw 16-bit data now and then
  // to hit masking and saturation, plus the odd write to an unused index.
  task automatic random_config();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(3))
      0:       v = 16'($urandom_range(65535));
      1:       v = 16'($urandom_range(15));
      default: v = 16'($urandom_range(int'(MODE_AA_SUB)));
    endcase
    set_reg(REG_MODE, v);
    case ($urandom_range(4))
      0:       v = 16'd0;
      1:       v = 16'(BLEND_MAX);
      2:       v = 16'($urandom_range(65535));
      default: v = 16'($urandom_range(int'(BLEND_MAX)));
    endcase
    set_reg(REG_BLEND, v);
    case ($urandom_range(4))
      0:       v = 16'd0;
      1:       v = 16'(GAIN_MAX);
      2:       v = 16'($urandom_range(65535));
      default: v = 16'($urandom_range(int'(GAIN_MAX)));
    endcase
    set_reg(REG_GAIN, v);
    case ($urandom_range(5))
      0:       v = 16'(int'(ROT_MIN));
      1:       v = 16'(int'(ROT_MAX));
      2:       v = 16'd0;
      3:       v = 16'($urandom_range(65535));
      default: v = 16'(int'($urandom_range(2000)) - 1000);
    endcase
    set_reg(REG_ROTATE, v);
    if ($urandom_range(2) == 0)
      set_reg(8'($urandom_range(255, 4)), 16'($urandom_range(65535)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb.reset_regs();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings first, then every mode at full blend and unit gain
    send_pix(8'd0, 8'd255);
    send_pix(8'd255, 8'd0);
    wait_drained();
    set_reg(REG_BLEND, 16'(BLEND_MAX));
    set_reg(REG_GAIN, 16'd1000);
    set_reg(REG_ROTATE, 16'd0);
    for (int m = 0; m <= int'(MODE_AA_SUB); m++) begin
      set_reg(REG_MODE, 16'(m));
      cfg_valid <= 1'b0;
      case (m)
        0: send_pix(8'd0, 8'd0);
        1: send_pix(8'd255, 8'd255);
        2: send_pix(8'd0, 8'd255);
        3: send_pix(8'd255, 8'd0);
        4: send_pix(8'd128, 8'd128);
        5: send_pix(8'd200, 8'd30);
        6: send_pix(8'd12, 8'd240);
        7: send_pix(8'd170, 8'd170);
        8: send_pix(8'd255, 8'd171);
        default: send_pix(8'd171, 8'd5);   // 0xaa - cb wraps below zero
      endcase
      wait_drained();
    end

    // Full positive rotation with maximum gain: clamps at both ends,
    // negative offsets truncated toward zero
    set_reg(REG_BLEND, 16'(BLEND_RST));
    set_reg(REG_GAIN, 16'(GAIN_MAX));
    set_reg(REG_ROTATE, 16'(int'(ROT_MAX)));
    cfg_valid <= 1'b0;
    send_pix(8'd0, 8'd255);
    send_pix(8'd255, 8'd0);
    send_pix(8'd127, 8'd129);
    wait_drained();

    // Full negative rotation, zero gain collapses to mid-gray
    set_reg(REG_ROTATE, 16'(int'(ROT_MIN)));
    set_reg(REG_GAIN, 16'd0);
    cfg_valid <= 1'b0;
    send_pix(8'd0, 8'd255);
    send_pix(8'd255, 8'd0);
    wait_drained();

    // Out-of-range data on every register, and writes to two unused indices
    set_reg(REG_MODE, 16'hffff);
    set_reg(REG_BLEND, 16'hffff);
    set_reg(REG_GAIN, 16'hffff);
    set_reg(REG_ROTATE, 16'h0400);      // -1024 after masking, saturates
    set_reg(8'h04, 16'h5a5a);
    set_reg(8'hff, 16'h0000);
    cfg_valid <= 1'b0;
    send_pix(8'd129, 8'd127);
    send_pix(8'd127, 8'd129);
    send_pix(8'd255, 8'd255);
    wait_drained();
    set_reg(REG_ROTATE, 16'h03ff);      // +1023, saturates to the top
    set_reg(REG_GAIN, 16'd999);
    cfg_valid <= 1'b0;
    send_pix(8'd1, 8'd254);
    wait_drained();

    // Random phases: sender-light/receiver-heavy idling, then the reverse,
    // then none. The long hold-off lands on the first no-idle phase.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < RAND_PHASES / 3) begin
        src_idle_pct  = 34;
        sink_idle_pct = 85;
      end else if (ph < 2 * RAND_PHASES / 3) begin
        src_idle_pct  = 85;
        sink_idle_pct = 34;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      random_config();
      if (ph == 2 * RAND_PHASES / 3) hold_armed = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_pix(rand_byte(), rand_byte());
      wait_drained();
    end

    repeat (NSTAGE * 4) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("chroma_remap_rotate_gain_top regression: pass");
    end else begin
      $display("chroma_remap_rotate_gain_top regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_TU);
    $display("chroma_remap_rotate_gain_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
